[hdl/fms_pkg.sv]
// ---------------------------------------------------------------------------
// Flight mode sequencer package
// Shared types, mode codes, register indexes and arithmetic helpers.
// ---------------------------------------------------------------------------
package fms_pkg;

    // Mode codes
    localparam logic [3:0] MODE_INIT   = 4'd0;
    localparam logic [3:0] MODE_BOOT   = 4'd1;
    localparam logic [3:0] MODE_WAIT   = 4'd2;
    localparam logic [3:0] MODE_ARMS   = 4'd3;
    localparam logic [3:0] MODE_BRAKE  = 4'd4;
    localparam logic [3:0] MODE_FLY    = 4'd5;
    localparam logic [3:0] MODE_LAND   = 4'd6;
    localparam logic [3:0] MODE_LANDED = 4'd7;
    localparam logic [3:0] MODE_SLEEP  = 4'd8;
    localparam logic [3:0] MODE_TEST   = 4'd9;
    localparam logic [3:0] MODE_CHUTE  = 4'd10;

    // Configuration register indexes
    localparam logic [2:0] REG_TARGET_ALT  = 3'd0;
    localparam logic [2:0] REG_GROUND_ALT  = 3'd1;
    localparam logic [2:0] REG_START_MODE  = 3'd2;
    localparam logic [2:0] REG_TLM_PERIOD  = 3'd3;
    localparam logic [2:0] REG_RELEASE     = 3'd4;

    // Fixed drive values and thresholds
    localparam logic [9:0]         ARM_OPEN       = 10'd1000;
    localparam logic signed [10:0] LIFT_ARMS      = -11'sd500;
    localparam logic signed [10:0] LIFT_BRAKE     = 11'sd1000;
    localparam logic [9:0]         THR_MAX        = 10'd1000;
    localparam logic signed [18:0] FLY_SINK       = 19'sd120;
    localparam logic signed [32:0] LAND_THRESHOLD = 33'sd10000;
    localparam logic signed [32:0] SETTLE_HEIGHT  = 33'sd2000;
    localparam logic signed [33:0] LAND_OFFSET    = 34'sd2000;
    localparam logic signed [33:0] TEST_OFFSET    = 34'sd10;
    localparam logic signed [33:0] TEST_TERM_HI   = 34'sd2047;
    localparam logic signed [33:0] TEST_TERM_LO   = -34'sd2048;

    // Division by 120 is done as a shift by 3 and a reciprocal multiply by 15
    localparam logic [19:0] RECIP_15   = 20'd559241;
    localparam int          RECIP_BITS = 23;

    // Pre-processed input word passed from the input stage to the core
    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [15:0] climb_rate;
        logic               climb_above;    // climb rate above release rate
        logic               below_land;     // height over target below land threshold
        logic               below_settle;   // height over target below settle height
        logic               err_neg;        // landing error is negative
        logic [21:0]        err_mag;        // saturated magnitude of landing error
        logic signed [11:0] test_term;      // saturated test hover term
    } fms_item_t;

    // Result word
    typedef struct packed {
        logic               sample_cycle;
        logic               parachute_open;
        logic [15:0]        telemetry_seq;
        logic               send_telemetry;
        logic signed [10:0] lift_drive;
        logic [9:0]         arm_drive;
        logic               drive_valid;
        logic [3:0]         mode;
    } fms_result_t;

    // Clamp a throttle sum to 0..1000
    function automatic logic [9:0] clamp_thr(input logic signed [18:0] v);
        logic [9:0] r;
        if (v > $signed({9'd0, THR_MAX}))
        begin
            r = THR_MAX;
        end
        else if (v < 19'sd0)
        begin
            r = 10'd0;
        end
        else
        begin
            r = v[9:0];
        end
        return r;
    endfunction

endpackage

[hdl/fms_prep.sv]
// ---------------------------------------------------------------------------
// Flight mode sequencer input stage
// Registers each input word together with the altitude differences and
// compares that depend only on the word and the configuration.
// ---------------------------------------------------------------------------
module fms_prep
    import fms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        now_ms,
    input  logic signed [15:0] climb_rate,
    input  logic signed [31:0] altitude,
    input  logic signed [31:0] target_altitude,
    input  logic signed [31:0] ground_altitude,
    input  logic [14:0]        release_rate,
    output logic               item_valid,
    input  logic               item_ready,
    output fms_item_t          item
);

    logic               valid_reg;
    fms_item_t          item_reg;
    fms_item_t          item_next;
    logic signed [32:0] height;
    logic signed [33:0] err;
    logic [33:0]        err_abs;
    logic signed [33:0] test_sum;

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Altitude differences, all exact
    always_comb
    begin
        height   = $signed({altitude[31], altitude})
                 - $signed({target_altitude[31], target_altitude});
        err      = $signed({height[32], height}) + LAND_OFFSET;
        err_abs  = err[33] ? 34'(-err) : 34'(err);
        test_sum = $signed({{2{ground_altitude[31]}}, ground_altitude}) + TEST_OFFSET
                 - $signed({{2{altitude[31]}}, altitude});

        item_next.now_ms       = now_ms;
        item_next.climb_rate   = climb_rate;
        item_next.climb_above  = $signed({climb_rate[15], climb_rate})
                               > $signed({2'b00, release_rate});
        item_next.below_land   = height < LAND_THRESHOLD;
        item_next.below_settle = height < SETTLE_HEIGHT;
        item_next.err_neg      = err[33];
        // Beyond 22 bits the throttle clamps either way
        item_next.err_mag      = (err_abs[33:22] != 12'd0) ? 22'h3FFFFF : err_abs[21:0];
        if (test_sum > TEST_TERM_HI)
        begin
            item_next.test_term = 12'sd2047;
        end
        else if (test_sum < TEST_TERM_LO)
        begin
            item_next.test_term = -12'sd2048;
        end
        else
        begin
            item_next.test_term = test_sum[11:0];
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

[hdl/fms_core.sv]
// ---------------------------------------------------------------------------
// Flight mode sequencer core
// Holds the mode, throttle, telemetry and settle state, steps them once per
// word and loads the result register.
// ---------------------------------------------------------------------------
module fms_core
    import fms_pkg::*;
#(
    parameter int SETTLE_TICKS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  fms_item_t   item,
    input  logic [3:0]  start_mode,
    input  logic [15:0] telemetry_period,
    output logic        out_valid,
    input  logic        out_ready,
    output fms_result_t result
);

    localparam logic [4:0] SETTLE_LIM = 5'(SETTLE_TICKS);
    localparam logic [4:0] SETTLE_MAX = 5'(SETTLE_TICKS + 1);

    logic [3:0]         mode_reg;
    logic [3:0]         mode_next;
    logic               not_started_reg;
    logic [9:0]         throttle_reg;
    logic [9:0]         throttle_next;
    logic [31:0]        last_send_reg;
    logic [31:0]        last_send_next;
    logic [4:0]         settle_reg;
    logic [4:0]         settle_next;
    logic [15:0]        frame_reg;
    logic [15:0]        frame_next;
    logic               out_valid_reg;
    fms_result_t        result_reg;
    fms_result_t        result_next;

    logic               advance;
    logic [3:0]         mode_cur;
    logic [31:0]        elapsed;
    logic               send;
    logic [38:0]        prod;
    logic [15:0]        quot;
    logic signed [18:0] thr_ext;
    logic signed [18:0] climb_ext;
    logic signed [18:0] land_term;
    logic signed [18:0] fly_sum;
    logic signed [18:0] land_sum;
    logic signed [18:0] test_sum;
    logic [4:0]         settle_inc;
    logic               settled;

    assign item_ready = !out_valid_reg || out_ready;
    assign advance    = item_valid && item_ready;
    assign out_valid  = out_valid_reg;
    assign result     = result_reg;

    // Throttle arithmetic; the landing error divided by 120 truncating
    always_comb
    begin
        prod      = 39'(item.err_mag[21:3]) * 39'(RECIP_15);
        quot      = prod[RECIP_BITS + 15:RECIP_BITS];
        thr_ext   = $signed({9'd0, throttle_reg});
        climb_ext = $signed({{3{item.climb_rate[15]}}, item.climb_rate});
        land_term = item.err_neg ? $signed({3'd0, quot}) : -$signed({3'd0, quot});
        fly_sum   = thr_ext - FLY_SINK + climb_ext;
        land_sum  = thr_ext + land_term + climb_ext;
        test_sum  = thr_ext + $signed({{7{item.test_term[11]}}, item.test_term});
    end

    // Saturating settle counter
    always_comb
    begin
        settle_inc = (settle_reg < SETTLE_MAX) ? settle_reg + 5'd1 : settle_reg;
        settled    = item.below_settle && (settle_inc > SETTLE_LIM);
    end

    // Telemetry due check
    always_comb
    begin
        elapsed = item.now_ms - last_send_reg;
        send    = elapsed > {16'd0, telemetry_period};
    end

    // Mode step
    always_comb
    begin
        if (not_started_reg)
        begin
            mode_cur = (start_mode > MODE_CHUTE) ? MODE_INIT : start_mode;
        end
        else
        begin
            mode_cur = mode_reg;
        end
        if (mode_cur == MODE_INIT || mode_cur == MODE_BOOT)
        begin
            mode_cur = MODE_WAIT;
        end

        mode_next      = mode_cur;
        throttle_next  = throttle_reg;
        settle_next    = settle_reg;
        last_send_next = send ? item.now_ms : last_send_reg;
        frame_next     = send ? frame_reg + 16'd1 : frame_reg;

        result_next                = '0;
        result_next.send_telemetry = send;
        result_next.telemetry_seq  = send ? frame_reg : 16'd0;

        unique case (mode_cur)
            MODE_WAIT:
            begin
                if (item.climb_above)
                begin
                    mode_next = MODE_ARMS;
                end
            end
            MODE_ARMS:
            begin
                result_next.drive_valid = 1'b1;
                result_next.arm_drive   = ARM_OPEN;
                result_next.lift_drive  = LIFT_ARMS;
                mode_next               = MODE_BRAKE;
            end
            MODE_BRAKE:
            begin
                result_next.drive_valid = 1'b1;
                result_next.lift_drive  = LIFT_BRAKE;
                if (!item.climb_above)
                begin
                    mode_next = MODE_FLY;
                end
            end
            MODE_FLY:
            begin
                throttle_next           = clamp_thr(fly_sum);
                result_next.drive_valid = 1'b1;
                result_next.lift_drive  = $signed({1'b0, throttle_next});
                if (item.below_land)
                begin
                    mode_next = MODE_LAND;
                end
            end
            MODE_LAND:
            begin
                throttle_next           = clamp_thr(land_sum);
                result_next.drive_valid = 1'b1;
                result_next.lift_drive  = $signed({1'b0, throttle_next});
                if (item.below_settle)
                begin
                    settle_next = settle_inc;
                end
                if (settled)
                begin
                    mode_next = MODE_LANDED;
                end
            end
            MODE_LANDED:
            begin
                result_next.drive_valid  = 1'b1;
                result_next.sample_cycle = 1'b1;
            end
            MODE_TEST:
            begin
                throttle_next = clamp_thr(test_sum);
            end
            MODE_CHUTE:
            begin
                result_next.parachute_open = 1'b1;
                if (item.below_settle)
                begin
                    settle_next = settle_inc;
                end
                if (settled)
                begin
                    mode_next = MODE_LAND;
                end
            end
            default:
            begin
                // Sleep holds with no drive
            end
        endcase

        result_next.mode = mode_next;
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_INIT;
            not_started_reg <= 1'b1;
            throttle_reg    <= 10'd0;
            last_send_reg   <= 32'd0;
            settle_reg      <= 5'd0;
            frame_reg       <= 16'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                mode_reg        <= mode_next;
                not_started_reg <= 1'b0;
                throttle_reg    <= throttle_next;
                last_send_reg   <= last_send_next;
                settle_reg      <= settle_next;
                frame_reg       <= frame_next;
            end
            if (item_ready)
            begin
                out_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

[hdl/flight_mode_sequencer_top.sv]
// ---------------------------------------------------------------------------
// Flight mode sequencer top level
// Configuration registers, input stage and sequencing core.
// ---------------------------------------------------------------------------
// Path: an accepted input word is held in the input register, which feeds the
// result register through one pass of logic.
// Throughput: one word per cycle while m_tready is high. While a result waits,
// one further word is taken into the input register, after which s_tready
// follows m_tready.
// Reset: rst_n clears all mode, throttle, telemetry and settle state at once;
// registers return to their reset values and no clearing pass is needed.
module flight_mode_sequencer_top
    import fms_pkg::*;
#(
    parameter int SETTLE_TICKS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,    // now_ms[31:0], climb_rate[47:32], altitude[79:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata     // mode[3:0], drive_valid[4], arm_drive[14:5],
                                    // lift_drive[25:15], send_telemetry[26],
                                    // telemetry_seq[42:27], parachute_open[43],
                                    // sample_cycle[44], zero[47:45]
);

    logic signed [31:0] target_alt_reg;
    logic signed [31:0] ground_alt_reg;
    logic [3:0]         start_mode_reg;
    logic [15:0]        tlm_period_reg;
    logic [14:0]        release_reg;

    logic               item_valid;
    logic               item_ready;
    fms_item_t          item;
    fms_result_t        result;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_alt_reg <= 32'sd0;
            ground_alt_reg <= 32'sd0;
            start_mode_reg <= MODE_INIT;
            tlm_period_reg <= 16'd500;
            release_reg    <= 15'd500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET_ALT: target_alt_reg <= cfg_data;
                REG_GROUND_ALT: ground_alt_reg <= cfg_data;
                REG_START_MODE: start_mode_reg <= cfg_data[3:0];
                REG_TLM_PERIOD: tlm_period_reg <= cfg_data[15:0];
                REG_RELEASE:    release_reg    <= cfg_data[14:0];
                default:
                begin
                    // Unused indexes are ignored
                end
            endcase
        end
    end

    // Input stage
    fms_prep u_prep (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .now_ms          (s_tdata[31:0]),
        .climb_rate      (s_tdata[47:32]),
        .altitude        (s_tdata[79:48]),
        .target_altitude (target_alt_reg),
        .ground_altitude (ground_alt_reg),
        .release_rate    (release_reg),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (item)
    );

    // Sequencing core
    fms_core #(
        .SETTLE_TICKS (SETTLE_TICKS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .item             (item),
        .start_mode       (start_mode_reg),
        .telemetry_period (tlm_period_reg),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .result           (result)
    );

    // Output word packing
    assign m_tdata = {3'b000, result.sample_cycle, result.parachute_open,
                      result.telemetry_seq, result.send_telemetry, result.lift_drive,
                      result.arm_drive, result.drive_valid, result.mode};

endmodule

[test/testbench.sv]
// ---------------------------------------------------------------------------
// Flight mode sequencer testbench
// Drives control ticks into the sequencer over the input stream and predicts
// each result word from a behavioural model held in the testbench. Every
// result word is checked field by field against the oldest prediction. The run
// covers field extremes, a guided flight from release to touchdown, and
// register settings at both ends of their ranges, with random idling on both
// sides of the block.
// ---------------------------------------------------------------------------
module testbench;
    import fms_pkg::*;

    localparam int SETTLE_TICKS     = 20;
    localparam int RESET_CYCLES     = 12;
    localparam int IDLE_PCT         = 7;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 4;
    localparam int MISMATCH_REPORTS = 10;

    // Thresholds and terms of the flight laws
    localparam longint FLARE_HEIGHT  = 10000;
    localparam longint TOUCH_HEIGHT  = 2000;
    localparam longint ERR_DIVISOR   = 120;
    localparam longint SINK_PER_TICK = 120;
    localparam longint HOVER_BIAS    = 10;
    localparam longint THROTTLE_TOP  = 1000;

    // Input field limits
    localparam longint CLIMB_MIN = -32768;
    localparam longint CLIMB_MAX = 32767;
    localparam longint ALT_MIN   = -longint'(32'h8000_0000);
    localparam longint ALT_MAX   = longint'(32'h7FFF_FFFF);

    // One control tick as carried on the input stream, lowest field last
    typedef struct packed {
        logic signed [31:0] altitude;
        logic signed [15:0] climb_rate;
        logic [31:0]        now_ms;
    } tick_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } reg_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;    // now_ms[31:0], climb_rate[47:32], altitude[79:48]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // mode, drive_valid, arm_drive, lift_drive,
                                  // send_telemetry, telemetry_seq,
                                  // parachute_open, sample_cycle, zero padding

    // Sequencer state as predicted by the testbench
    logic [3:0]  fm_mode = MODE_INIT;
    bit          awaiting_first = 1'b1;
    longint      throttle = 0;
    logic [31:0] last_send = '0;
    int          settle_cnt = 0;
    logic [15:0] frame_seq = '0;

    // Register copies as the block should hold them
    logic signed [31:0] target_alt = '0;
    logic signed [31:0] ground_alt = '0;
    logic [3:0]         start_sel = MODE_INIT;
    logic [15:0]        tlm_period = 16'd500;
    logic [14:0]        release_thr = 15'd500;

    fms_result_t pending_results[$];
    reg_write_t  staged_writes[$];

    logic [31:0] clock_ms = '0;
    logic [3:0]  start_choice = MODE_INIT;
    logic [15:0] modes_seen = '0;
    bit          calm = 1'b0;
    bit          valid_held = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned ticks_sent = 0;
    int unsigned results_checked = 0;
    int unsigned frames_due = 0;
    int unsigned mismatches = 0;

    flight_mode_sequencer_top #(
        .SETTLE_TICKS(SETTLE_TICKS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    // The receiving side stalls at random except during the full-rate stretch.
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int pick_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic longint clamp_throttle(input longint v);
        return clip(v, 0, THROTTLE_TOP);
    endfunction

    // Touchdown confirmation: counts ticks close to the target, saturating.
    function automatic bit settled(input longint height);
        if (height < TOUCH_HEIGHT)
        begin
            if (settle_cnt < SETTLE_TICKS + 1)
            begin
                settle_cnt++;
            end
            if (settle_cnt > SETTLE_TICKS)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advances the predicted sequencer by one tick and returns its result word.
    function automatic fms_result_t advance_sequencer(input tick_t t);
        fms_result_t r;
        longint      climb;
        longint      height;
        longint      err;
        logic [31:0] since;
        r = '0;
        climb = longint'(t.climb_rate);
        height = longint'(t.altitude) - longint'(target_alt);

        // The first tick restores the start mode; init and boot fall through.
        if (awaiting_first)
        begin
            fm_mode = (start_sel > MODE_CHUTE) ? MODE_INIT : start_sel;
            awaiting_first = 1'b0;
        end
        if (fm_mode == MODE_INIT || fm_mode == MODE_BOOT)
        begin
            fm_mode = MODE_WAIT;
        end

        // Telemetry is due in every mode once the period has been exceeded.
        since = t.now_ms - last_send;
        if (since > {16'd0, tlm_period})
        begin
            last_send = t.now_ms;
            r.send_telemetry = 1'b1;
            r.telemetry_seq = frame_seq;
            frame_seq = frame_seq + 16'd1;
            frames_due++;
        end

        case (fm_mode)
            MODE_WAIT:
            begin
                if (climb > longint'(release_thr))
                begin
                    fm_mode = MODE_ARMS;
                end
            end
            MODE_ARMS:
            begin
                r.drive_valid = 1'b1;
                r.arm_drive = ARM_OPEN;
                r.lift_drive = LIFT_ARMS;
                fm_mode = MODE_BRAKE;
            end
            MODE_BRAKE:
            begin
                r.drive_valid = 1'b1;
                r.lift_drive = LIFT_BRAKE;
                if (climb <= longint'(release_thr))
                begin
                    fm_mode = MODE_FLY;
                end
            end
            MODE_FLY:
            begin
                throttle = clamp_throttle(throttle - SINK_PER_TICK + climb);
                r.drive_valid = 1'b1;
                r.lift_drive = 11'(throttle);
                if (height < FLARE_HEIGHT)
                begin
                    fm_mode = MODE_LAND;
                end
            end
            MODE_LAND:
            begin
                // Division truncates toward zero, as in the core.
                err = height + TOUCH_HEIGHT;
                throttle = clamp_throttle(throttle + (-err) / ERR_DIVISOR + climb);
                r.drive_valid = 1'b1;
                r.lift_drive = 11'(throttle);
                if (settled(height))
                begin
                    fm_mode = MODE_LANDED;
                end
            end
            MODE_LANDED:
            begin
                r.drive_valid = 1'b1;
                r.sample_cycle = 1'b1;
            end
            MODE_TEST:
            begin
                // Hover integrator runs, but nothing is driven.
                throttle = clamp_throttle(throttle + longint'(ground_alt) + HOVER_BIAS
                                          - longint'(t.altitude));
            end
            MODE_CHUTE:
            begin
                r.parachute_open = 1'b1;
                if (settled(height))
                begin
                    fm_mode = MODE_LAND;
                end
            end
            default:
            begin
            end
        endcase

        r.mode = fm_mode;
        modes_seen[fm_mode] = 1'b1;
        return r;
    endfunction

    function automatic void apply_register(input logic [2:0] index, input logic [31:0] data);
        case (index)
            REG_TARGET_ALT: target_alt = data;
            REG_GROUND_ALT: ground_alt = data;
            REG_START_MODE: start_sel = data[3:0];
            REG_TLM_PERIOD: tlm_period = data[15:0];
            REG_RELEASE:    release_thr = data[14:0];
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [3:0] pick_start_mode();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
        begin
            return 4'(MODE_CHUTE + pick_between(1, 5));
        end
        else if (roll < 50)
        begin
            return 4'(pick_between(MODE_INIT, MODE_WAIT));
        end
        else if (roll < 62)
        begin
            return MODE_TEST;
        end
        else if (roll < 74)
        begin
            return MODE_CHUTE;
        end
        else if (roll < 80)
        begin
            return MODE_SLEEP;
        end
        else if (roll < 86)
        begin
            return MODE_LANDED;
        end
        return 4'(pick_between(MODE_ARMS, MODE_LAND));
    endfunction

    // Chooses the next tick so that the predicted flight moves on slowly:
    // most ticks hold the current mode, a few push it to the next one.
    function automatic tick_t plan_tick();
        tick_t  t;
        longint rel;
        longint climb;
        longint height;
        longint alt;
        rel = longint'(release_thr);
        climb = pick_between(-2000, 2000);
        height = pick_between(-100000, 100000);

        // Time mostly creeps forward; sometimes it lands on the telemetry
        // boundary or jumps anywhere, wrap included.
        case ($urandom_range(9))
            0:       clock_ms = $urandom;
            1, 2:    clock_ms = last_send + tlm_period + $urandom_range(2) - 1;
            default: clock_ms = clock_ms + $urandom_range(300);
        endcase

        case (fm_mode)
            MODE_INIT, MODE_BOOT, MODE_WAIT:
            begin
                climb = ($urandom_range(24) == 0) ? rel + pick_between(1, 60)
                                                  : rel - pick_between(0, 3000);
            end
            MODE_BRAKE:
            begin
                climb = ($urandom_range(4) == 0) ? rel - pick_between(0, 300)
                                                 : rel + pick_between(1, 3000);
            end
            MODE_FLY:
            begin
                climb = pick_between(-100, 360);
                if ($urandom_range(149) == 0)
                begin
                    height = pick_between(-3000, 9999);
                end
                else if ($urandom_range(39) == 0)
                begin
                    height = FLARE_HEIGHT;
                end
                else
                begin
                    height = pick_between(10000, 60000);
                end
            end
            MODE_LAND, MODE_CHUTE:
            begin
                climb = pick_between(-150, 250);
                height = ($urandom_range(7) == 0) ? pick_between(-6000, 1999)
                                                  : pick_between(2000, 4500);
            end
            default:
            begin
            end
        endcase

        if (fm_mode == MODE_TEST && $urandom_range(9) != 0)
        begin
            alt = longint'(ground_alt) + HOVER_BIAS + pick_between(-300, 300);
        end
        else if (fm_mode == MODE_TEST)
        begin
            alt = longint'($signed($urandom));
        end
        else
        begin
            alt = longint'(target_alt) + height;
        end

        t.now_ms = clock_ms;
        t.climb_rate = 16'(clip(climb, CLIMB_MIN, CLIMB_MAX));
        t.altitude = 32'(clip(alt, ALT_MIN, ALT_MAX));

        // Occasional noise word; the height is kept where the flight depends on it.
        if ($urandom_range(39) == 0)
        begin
            t.now_ms = $urandom;
            t.climb_rate = 16'($urandom);
            clock_ms = t.now_ms;
            if (fm_mode != MODE_FLY && fm_mode != MODE_LAND && fm_mode != MODE_CHUTE)
            begin
                t.altitude = $urandom;
            end
        end
        return t;
    endfunction

    // Drives s_tvalid only when its level changes, so a step never sees two.
    task automatic set_word_valid(input bit v);
        if (v != valid_held)
        begin
            s_tvalid <= v;
            valid_held = v;
        end
    endtask

    // Offers one tick and records its predicted result once it is accepted.
    task automatic send_tick(input tick_t t);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            set_word_valid(1'b0);
            @(posedge clk);
        end
        set_word_valid(1'b1);
        s_tdata <= t;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pending_results.push_back(advance_sequencer(t));
        ticks_sent++;
    endtask

    task automatic wait_drained();
        set_word_valid(1'b0);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic stage_write(input logic [2:0] index, input logic [31:0] data);
        reg_write_t w;
        w.index = index;
        w.data = data;
        staged_writes.push_back(w);
    endtask

    // Writes every staged register, one per cycle, while the block is idle.
    task automatic program_registers();
        reg_write_t w;
        while (staged_writes.size() != 0)
        begin
            w = staged_writes.pop_front();
            cfg_we <= 1'b1;
            cfg_index <= w.index;
            cfg_data <= w.data;
            @(posedge clk);
            apply_register(w.index, w.data);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic note_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MISMATCH_REPORTS)
            begin
                $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                         name, results_checked, want, got);
            end
        end
    endtask

    // Each accepted result word is compared with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        fms_result_t want;
        fms_result_t got;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MISMATCH_REPORTS)
                begin
                    $display("Result word %h arrived with no tick outstanding", m_tdata);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                got = m_tdata[44:0];
                note_field("mode", want.mode, got.mode);
                note_field("drive_valid", want.drive_valid, got.drive_valid);
                note_field("arm_drive", want.arm_drive, got.arm_drive);
                note_field("lift_drive", want.lift_drive, got.lift_drive);
                note_field("send_telemetry", want.send_telemetry, got.send_telemetry);
                note_field("telemetry_seq", want.telemetry_seq, got.telemetry_seq);
                note_field("parachute_open", want.parachute_open, got.parachute_open);
                note_field("sample_cycle", want.sample_cycle, got.sample_cycle);
                note_field("padding", 0, m_tdata[47:45]);
                results_checked++;
            end
        end
    end

    task automatic run_flight(input int count);
        repeat (count)
        begin
            // Now and then the sender holds off until the block has emptied.
            if ($urandom_range(149) == 0)
            begin
                wait_drained();
            end
            send_tick(plan_tick());
        end
    endtask

    function automatic logic [2:0] spare_index();
        return 3'(REG_RELEASE + 1 + $urandom_range(2));
    endfunction

    // Moderate settings and the start mode, written before the first tick.
    task automatic test_power_up_registers();
        logic [31:0] junk;
        junk = $urandom;
        start_choice = pick_start_mode();
        stage_write(REG_TARGET_ALT, 32'(pick_between(-50000, 50000)));
        stage_write(REG_GROUND_ALT, 32'(pick_between(-50000, 50000)));
        stage_write(REG_START_MODE, {junk[31:4], start_choice});
        stage_write(REG_TLM_PERIOD, {junk[31:16], 16'(pick_between(50, 1000))});
        stage_write(REG_RELEASE, {junk[31:15], 15'(pick_between(100, 2000))});
        stage_write(spare_index(), $urandom);
        program_registers();
    endtask

    // Telemetry boundaries first, then every pairing of climb and altitude
    // extremes, with time swinging across the wrap.
    task automatic test_field_extremes();
        tick_t  t;
        longint climbs[3];
        longint alts[3];
        int     n;
        climbs = '{0, CLIMB_MIN, CLIMB_MAX};
        alts = '{ALT_MIN, 0, ALT_MAX};
        n = 0;
        t = '0;
        repeat (2)
        begin
            t.now_ms = last_send + tlm_period;
            send_tick(t);
            t.now_ms = last_send + tlm_period + 1;
            send_tick(t);
        end
        foreach (climbs[c])
        begin
            foreach (alts[a])
            begin
                t.climb_rate = 16'(climbs[c]);
                t.altitude = 32'(alts[a]);
                t.now_ms = n[0] ? 32'hFFFF_FFFF : 32'(n * 7);
                send_tick(t);
                n++;
            end
        end
        clock_ms = t.now_ms;
    endtask

    task automatic test_moderate_flight();
        run_flight(450);
    endtask

    // Lowest period and release rate, extreme altitudes, and a start mode
    // written after the first tick, which must change nothing.
    task automatic test_floor_settings();
        logic [31:0] junk;
        junk = $urandom;
        wait_drained();
        stage_write(REG_TARGET_ALT, 32'h8000_0000);
        stage_write(REG_GROUND_ALT, 32'h7FFF_FFFF);
        stage_write(REG_TLM_PERIOD, {junk[31:16], 16'h0000});
        stage_write(REG_RELEASE, {junk[31:15], 15'h0000});
        stage_write(REG_START_MODE,
                    {junk[31:4], (start_choice == MODE_TEST) ? MODE_CHUTE : MODE_TEST});
        program_registers();
        run_flight(300);
    endtask

    task automatic test_ceiling_settings();
        logic [31:0] junk;
        junk = $urandom;
        wait_drained();
        stage_write(REG_TARGET_ALT, 32'h7FFF_FFFF);
        stage_write(REG_GROUND_ALT, 32'h8000_0000);
        stage_write(REG_TLM_PERIOD, {junk[31:16], 16'hFFFF});
        stage_write(REG_RELEASE, {junk[31:15], 15'h7FFF});
        stage_write(spare_index(), $urandom);
        program_registers();
        run_flight(250);
    endtask

    // Back to moderate settings with neither side idling.
    task automatic test_full_rate();
        wait_drained();
        calm = 1'b1;
        stage_write(REG_TARGET_ALT, 32'(pick_between(-50000, 50000)));
        stage_write(REG_GROUND_ALT, 32'(pick_between(-50000, 50000)));
        stage_write(REG_TLM_PERIOD, 32'(pick_between(1, 400)));
        stage_write(REG_RELEASE, 32'(pick_between(1, 1500)));
        program_registers();
        run_flight(250);
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_power_up_registers();
        test_field_extremes();
        test_moderate_flight();
        test_floor_settings();
        test_ceiling_settings();
        test_full_rate();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d ticks and checked %0d result words; %0d telemetry frames were due.",
                 ticks_sent, results_checked, frames_due);
        $display("Start mode %0d, modes reached (one bit per mode) %b, %0d mismatches.",
                 start_choice, modes_seen[10:0], mismatches);
        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
